// ===== rtl/core/dfmd_pkg.sv =====
// ----------------------------------------------------------------------------
// Depth frame motion detector package
// Shared types, register codes and reset values for the detector core.
// ----------------------------------------------------------------------------
package dfmd_pkg;

    localparam int SENSOR_COUNT_DEF    = 3;
    localparam int CELLS_PER_FRAME_DEF = 64;

    localparam int DIST_W    = 16;
    localparam int CNT_W     = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [DIST_W-1:0] TRIGGER_MAX_RST  = 16'd1650;
    localparam logic [DIST_W-1:0] MOTION_DELTA_RST = 16'd85;
    localparam logic [CNT_W-1:0]  TRIGGER_MIN_RST  = 8'd2;
    localparam logic [CNT_W-1:0]  MOTION_MIN_RST   = 8'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRIGGER_MAX  = 2'd0,
        CFG_MOTION_DELTA = 2'd1,
        CFG_TRIGGER_MIN  = 2'd2,
        CFG_MOTION_MIN   = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]        sensor;
        logic [5:0]        cell_req;
        logic [DIST_W-1:0] distance;
        logic              cell_present;
        logic              frame_last;
    } dfmd_in_t;

    typedef struct packed {
        logic             activity;
        logic [CNT_W-1:0] active_cells;
        logic [CNT_W-1:0] moving_cells;
        logic             any_sensor;
    } dfmd_out_t;

    typedef struct packed {
        logic active;
        logic moving;
    } cell_flags_t;

endpackage

// ===== rtl/core/dfmd_depth_store.sv =====
// ----------------------------------------------------------------------------
// Previous depth store
// One write port and one registered read port, with a bypass for a write
// to the same entry in the same cycle as the read.
// ----------------------------------------------------------------------------
module dfmd_depth_store #(
    parameter int DEPTH  = dfmd_pkg::SENSOR_COUNT_DEF * dfmd_pkg::CELLS_PER_FRAME_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                        aclk,
    input  logic                        rd_en,
    input  logic [ADDR_W-1:0]           rd_addr,
    output logic [dfmd_pkg::DIST_W-1:0] rd_data,
    input  logic                        wr_en,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [dfmd_pkg::DIST_W-1:0] wr_data
);

    logic [dfmd_pkg::DIST_W-1:0] depth_mem_reg [DEPTH];
    logic [dfmd_pkg::DIST_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            depth_mem_reg[wr_addr] <= wr_data;
        end
    end

    // A write landing at the same edge returns the new value.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_data_reg <= wr_data;
            end else begin
                rd_data_reg <= depth_mem_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/dfmd_cell_eval.sv =====
// ----------------------------------------------------------------------------
// Cell evaluation
// Classifies one depth cell as active and as moving against its previous value.
// ----------------------------------------------------------------------------
module dfmd_cell_eval (
    input  logic                        cell_ok,
    input  logic                        has_prev,
    input  logic [dfmd_pkg::DIST_W-1:0] distance,
    input  logic [dfmd_pkg::DIST_W-1:0] prev_distance,
    input  logic [dfmd_pkg::DIST_W-1:0] trigger_max,
    input  logic [dfmd_pkg::DIST_W-1:0] motion_delta,
    output dfmd_pkg::cell_flags_t       flags
);

    logic                        cur_active;
    logic                        prev_active;
    logic [dfmd_pkg::DIST_W-1:0] abs_delta;

    always_comb begin
        cur_active  = (distance != '0) && (distance <= trigger_max);
        prev_active = (prev_distance != '0) && (prev_distance <= trigger_max);
        if (distance > prev_distance) begin
            abs_delta = distance - prev_distance;
        end else begin
            abs_delta = prev_distance - distance;
        end
        flags.active = cell_ok && cur_active;
        flags.moving = cell_ok && has_prev && (cur_active || prev_active)
                       && (abs_delta >= motion_delta);
    end

endmodule

// ===== rtl/core/depth_frame_motion_detector.sv =====
// ----------------------------------------------------------------------------
// Depth frame motion detector
// Counts active and moving depth cells per frame over several sensors and
// reports activity when a frame closes.
// ----------------------------------------------------------------------------
// A closing word passes the input register, which reads its previous depth, then
// the result register, which drives m_valid. Throughput: one word per cycle; the
// single depth store read and write port each serve one cell per cycle. Only a
// stalled result blocks a closing word. Reset: synchronous, active low.
// Configuration returns to its defaults, all counts and per-sensor history bits
// clear. The depth store is not cleared; the user must ensure that an entry is
// read only once its sensor closed a frame that wrote it; the block does not check.
// ----------------------------------------------------------------------------
module depth_frame_motion_detector #(
    parameter int SENSOR_COUNT    = dfmd_pkg::SENSOR_COUNT_DEF,
    parameter int CELLS_PER_FRAME = dfmd_pkg::CELLS_PER_FRAME_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Cell input channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  dfmd_pkg::dfmd_in_t              s_data,
    // Frame result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output dfmd_pkg::dfmd_out_t             m_data,
    // Configuration write port
    input  logic                            cfg_wr_en,
    input  logic [dfmd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dfmd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    localparam int DEPTH   = SENSOR_COUNT * CELLS_PER_FRAME;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int WIDE_W  = 10;
    localparam int CNT_W   = dfmd_pkg::CNT_W;
    localparam int DIST_W  = dfmd_pkg::DIST_W;
    localparam logic [CNT_W-1:0] CNT_LIMIT = (DEPTH > 255) ? 8'd255 : CNT_W'(DEPTH);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [DIST_W-1:0] trigger_max_reg;
    logic [DIST_W-1:0] motion_delta_reg;
    logic [CNT_W-1:0]  trigger_min_reg;
    logic [CNT_W-1:0]  motion_min_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trigger_max_reg  <= dfmd_pkg::TRIGGER_MAX_RST;
            motion_delta_reg <= dfmd_pkg::MOTION_DELTA_RST;
            trigger_min_reg  <= dfmd_pkg::TRIGGER_MIN_RST;
            motion_min_reg   <= dfmd_pkg::MOTION_MIN_RST;
        end else if (cfg_wr_en) begin
            case (dfmd_pkg::cfg_idx_t'(cfg_index))
                dfmd_pkg::CFG_TRIGGER_MAX:  trigger_max_reg  <= cfg_wdata[DIST_W-1:0];
                dfmd_pkg::CFG_MOTION_DELTA: motion_delta_reg <= cfg_wdata[DIST_W-1:0];
                dfmd_pkg::CFG_TRIGGER_MIN:  trigger_min_reg  <= cfg_wdata[CNT_W-1:0];
                dfmd_pkg::CFG_MOTION_MIN:   motion_min_reg   <= cfg_wdata[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake. The input register empties whenever its word can retire:
    // a word that does not close a frame always retires, a closing word
    // retires once the result register is free or being drained.
    // ------------------------------------------------------------------
    dfmd_pkg::dfmd_in_t  in_reg;
    logic                in_valid_reg;
    dfmd_pkg::dfmd_out_t out_reg, out_next;
    logic                out_valid_reg;

    logic out_free;
    logic retire;
    logic accept;

    assign out_free = !out_valid_reg || m_ready;
    assign retire   = in_valid_reg && (!in_reg.frame_last || out_free);
    assign s_ready  = !in_valid_reg || retire;
    assign accept   = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_reg <= s_data;
        end
    end

    // ------------------------------------------------------------------
    // Previous depth store: read as a word is accepted, written as it
    // retires. A repeated cell right behind its predecessor is bypassed.
    // ------------------------------------------------------------------
    logic [WIDE_W-1:0] rd_wide, wr_wide;
    logic [DIST_W-1:0] prev_distance;
    logic              cell_ok;

    assign rd_wide = WIDE_W'(s_data.sensor) * WIDE_W'(CELLS_PER_FRAME)
                     + WIDE_W'(s_data.cell_req);
    assign wr_wide = WIDE_W'(in_reg.sensor) * WIDE_W'(CELLS_PER_FRAME)
                     + WIDE_W'(in_reg.cell_req);

    dfmd_depth_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (rd_wide[ADDR_W-1:0]),
        .rd_data (prev_distance),
        .wr_en   (retire && cell_ok),
        .wr_addr (wr_wide[ADDR_W-1:0]),
        .wr_data (in_reg.distance)
    );

    // ------------------------------------------------------------------
    // Cell classification for the word in the input register. Cells from
    // a sensor or cell index beyond the configured frame are ignored.
    // ------------------------------------------------------------------
    logic [SENSOR_COUNT-1:0] sensor_mask;
    logic [SENSOR_COUNT-1:0] has_prev_reg, has_prev_next;
    logic [SENSOR_COUNT-1:0] frame_sensors_reg, frame_sensors_next;
    logic                    has_prev;
    dfmd_pkg::cell_flags_t   flags;

    always_comb begin
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            sensor_mask[i] = ({2'b00, in_reg.sensor} == 4'(i));
        end
    end

    assign cell_ok  = in_reg.cell_present
                      && ({2'b00, in_reg.sensor} < 4'(SENSOR_COUNT))
                      && ({1'b0, in_reg.cell_req} < 7'(CELLS_PER_FRAME));
    assign has_prev = |(sensor_mask & has_prev_reg);

    dfmd_cell_eval u_eval (
        .cell_ok       (cell_ok),
        .has_prev      (has_prev),
        .distance      (in_reg.distance),
        .prev_distance (prev_distance),
        .trigger_max   (trigger_max_reg),
        .motion_delta  (motion_delta_reg),
        .flags         (flags)
    );

    // ------------------------------------------------------------------
    // Frame accumulation. Counts saturate at the number of cells a frame
    // can hold, at most 255. A closing word folds its own cell in first,
    // then the result is built and the frame state starts over.
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] active_cnt_reg, active_cnt_next, active_cnt_inc;
    logic [CNT_W-1:0] moving_cnt_reg, moving_cnt_next, moving_cnt_inc;
    logic             had_sensor_reg, had_sensor_next, had_sensor_inc;
    logic             had_prev_reg, had_prev_next, had_prev_inc;
    logic             out_valid_next;
    logic             close;

    assign close = retire && in_reg.frame_last;

    always_comb begin
        active_cnt_inc = active_cnt_reg;
        moving_cnt_inc = moving_cnt_reg;
        if (flags.active && (active_cnt_reg < CNT_LIMIT)) begin
            active_cnt_inc = active_cnt_reg + 1'b1;
        end
        if (flags.moving && (moving_cnt_reg < CNT_LIMIT)) begin
            moving_cnt_inc = moving_cnt_reg + 1'b1;
        end
        had_sensor_inc = had_sensor_reg || cell_ok;
        had_prev_inc   = had_prev_reg || (cell_ok && has_prev);

        frame_sensors_next = frame_sensors_reg;
        has_prev_next      = has_prev_reg;
        active_cnt_next    = active_cnt_reg;
        moving_cnt_next    = moving_cnt_reg;
        had_sensor_next    = had_sensor_reg;
        had_prev_next      = had_prev_reg;

        out_next.any_sensor   = had_sensor_inc;
        out_next.active_cells = active_cnt_inc;
        out_next.moving_cells = moving_cnt_inc;
        out_next.activity     = had_sensor_inc
                                && (active_cnt_inc >= trigger_min_reg)
                                && (!had_prev_inc || (moving_cnt_inc >= motion_min_reg));

        if (retire) begin
            if (cell_ok) begin
                frame_sensors_next = frame_sensors_reg | sensor_mask;
            end
            active_cnt_next = active_cnt_inc;
            moving_cnt_next = moving_cnt_inc;
            had_sensor_next = had_sensor_inc;
            had_prev_next   = had_prev_inc;
            if (in_reg.frame_last) begin
                has_prev_next      = has_prev_reg | frame_sensors_next;
                frame_sensors_next = '0;
                active_cnt_next    = '0;
                moving_cnt_next    = '0;
                had_sensor_next    = 1'b0;
                had_prev_next      = 1'b0;
            end
        end

        if (close) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_sensors_reg <= '0;
            has_prev_reg      <= '0;
            active_cnt_reg    <= '0;
            moving_cnt_reg    <= '0;
            had_sensor_reg    <= 1'b0;
            had_prev_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end else begin
            frame_sensors_reg <= frame_sensors_next;
            has_prev_reg      <= has_prev_next;
            active_cnt_reg    <= active_cnt_next;
            moving_cnt_reg    <= moving_cnt_next;
            had_sensor_reg    <= had_sensor_next;
            had_prev_reg      <= had_prev_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (close) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // An empty input register always takes a new word.
    a_ready_when_empty : assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("input stalled while the input register is empty");

    // Counts never pass the saturation limit.
    a_count_limit : assert property (@(posedge aclk) disable iff (!aresetn)
        (active_cnt_reg <= CNT_LIMIT) && (moving_cnt_reg <= CNT_LIMIT))
        else $error("frame count above its saturation limit");

    // A closing word always produces a result in the next cycle.
    a_close_result : assert property (@(posedge aclk) disable iff (!aresetn)
        close |=> m_valid)
        else $error("closed frame without a result");

    // A taken result is not repeated unless a new frame closed.
    a_no_repeat : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !close) |=> !m_valid)
        else $error("result repeated after it was taken");

endmodule

// ===== tb/tb_depth_frame_motion_detector.sv =====
// ----------------------------------------------------------------------------
// Depth frame motion detector testbench
// Streams depth cell words from three sensors into the detector and checks
// every frame report against a cycle-free predictor kept in the testbench.
// Directed frames cover count saturation, threshold boundaries, markers and
// ignored sensors. Random frames follow, under several register settings and
// with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_depth_frame_motion_detector;
    timeunit 1ns;
    timeprecision 1ps;

    import dfmd_pkg::*;

    localparam int SENSORS     = SENSOR_COUNT_DEF;
    localparam int CELLS       = CELLS_PER_FRAME_DEF;
    localparam int STORE_CELLS = SENSORS * CELLS;
    localparam int COUNT_CEIL  = (STORE_CELLS > 255) ? 255 : STORE_CELLS;
    // Cycles without any accepted word before the run is declared hung.
    localparam int HANG_LIMIT  = 2000;
    // A closing word passes the input register, then the result register, to show up as a report.
    localparam int PIPE_SLACK  = 4;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    dfmd_in_t    s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    dfmd_out_t   m_data;
    logic        cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    depth_frame_motion_detector uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state. The register copies follow every write we issue,
    // and the frame state follows every accepted cell word.
    // ------------------------------------------------------------------
    logic [DIST_W-1:0] limit_mm   = TRIGGER_MAX_RST;
    logic [DIST_W-1:0] delta_mm   = MOTION_DELTA_RST;
    logic [CNT_W-1:0]  min_active = TRIGGER_MIN_RST;
    logic [CNT_W-1:0]  min_moving = MOTION_MIN_RST;

    logic [DIST_W-1:0] depth_mem [STORE_CELLS];
    logic              cell_seen [STORE_CELLS];
    logic [SENSORS-1:0] sensor_warm  = '0;
    logic [SENSORS-1:0] open_sensors = '0;
    int                n_active       = 0;
    int                n_moving       = 0;
    logic              open_has_cells = 1'b0;
    logic              open_has_warm  = 1'b0;

    // Frame reports still owed by the block, oldest first.
    dfmd_out_t frame_reports_q[$];

    int   mismatch_count  = 0;
    int   words_sent      = 0;
    int   idle_cycles     = 0;
    int   stall_left      = 0;
    logic sender_gaps     = 1'b0;
    logic receiver_stalls = 1'b0;

    function automatic int pick_gap_len();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic in_range(input logic [DIST_W-1:0] mm);
        return mm != '0 && mm <= limit_mm;
    endfunction

    function automatic dfmd_in_t cell_word(input int sensor_sel, input int cell_idx,
                                           input int mm,
                                           input logic present, input logic last);
        dfmd_in_t w;
        w.sensor       = 2'(sensor_sel);
        w.cell_req     = 6'(cell_idx);
        w.distance     = DIST_W'(mm);
        w.cell_present = present;
        w.frame_last   = last;
        return w;
    endfunction

    // Applies one accepted word to the predictor. A closing word queues the
    // report for the frame and hands the frame's sensors their history bit.
    task automatic count_cell_word(input dfmd_in_t w);
        int                idx;
        logic              warm;
        logic              now_on;
        logic [DIST_W-1:0] old;
        logic [DIST_W-1:0] diff;
        dfmd_out_t         r;
        if (w.cell_present && w.sensor < SENSORS && w.cell_req < CELLS) begin
            idx    = int'(w.sensor) * CELLS + int'(w.cell_req);
            warm   = sensor_warm[w.sensor];
            now_on = in_range(w.distance);
            open_sensors[w.sensor] = 1'b1;
            open_has_cells = 1'b1;
            if (warm) open_has_warm = 1'b1;
            if (now_on && n_active < COUNT_CEIL) n_active++;
            if (warm) begin
                old  = depth_mem[idx];
                diff = (w.distance > old) ? w.distance - old : old - w.distance;
                if ((now_on || in_range(old)) && diff >= delta_mm && n_moving < COUNT_CEIL)
                    n_moving++;
            end
            depth_mem[idx] = w.distance;
            cell_seen[idx] = 1'b1;
        end
        if (w.frame_last) begin
            r.activity     = open_has_cells && n_active >= min_active &&
                             (!open_has_warm || n_moving >= min_moving);
            r.active_cells = n_active[CNT_W-1:0];
            r.moving_cells = n_moving[CNT_W-1:0];
            r.any_sensor   = open_has_cells;
            frame_reports_q.push_back(r);
            sensor_warm    = sensor_warm | open_sensors;
            open_sensors   = '0;
            n_active       = 0;
            n_moving       = 0;
            open_has_cells = 1'b0;
            open_has_warm  = 1'b0;
        end
    endtask

    // Sends one word. An optional gap with valid low comes first; when there
    // is no gap, valid simply stays high from the previous word.
    task automatic send_word(input dfmd_in_t w);
        int gap;
        gap = (sender_gaps && $urandom_range(0, 99) < 40) ? pick_gap_len() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        count_cell_word(w);
        words_sent++;
    endtask

    // Holds the sender off until every owed report has come back, then lets
    // the pipeline run dry of words that produce no report.
    task automatic wait_for_reports();
        s_valid <= 1'b0;
        while (frame_reports_q.size() != 0) @(posedge aclk);
        repeat (PIPE_SLACK) @(posedge aclk);
    endtask

    // Writes all four registers, one per edge, while the block is idle.
    task automatic load_settings(input logic [DIST_W-1:0] lim, input logic [DIST_W-1:0] dlt,
                                 input logic [CNT_W-1:0] mina, input logic [CNT_W-1:0] minm);
        cfg_idx_t              regs [4];
        logic [CFG_DATA_W-1:0] vals [4];
        regs = '{CFG_TRIGGER_MAX, CFG_MOTION_DELTA, CFG_TRIGGER_MIN, CFG_MOTION_MIN};
        vals = '{lim, dlt, CFG_DATA_W'(mina), CFG_DATA_W'(minm)};
        wait_for_reports();
        for (int i = 0; i < 4; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= regs[i];
            cfg_wdata <= vals[i];
            @(posedge aclk);
        end
        cfg_wr_en  <= 1'b0;
        limit_mm   = lim;
        delta_mm   = dlt;
        min_active = mina;
        min_moving = minm;
    endtask

    // Distances cluster around the active limit and around the stored value
    // plus or minus the motion delta, where the decisions flip.
    function automatic logic [DIST_W-1:0] pick_mm(input int idx);
        logic [DIST_W-1:0] off;
        off = DIST_W'($urandom_range(0, 2)) - 16'd1;
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return limit_mm + off;
            4, 5:    return depth_mem[idx] + delta_mm + off;
            6:       return depth_mem[idx] - delta_mm + off;
            7:       return DIST_W'($urandom);
            default: return DIST_W'($urandom_range(0, 3000));
        endcase
    endfunction

    // A sensor with history may only revisit cells it has already written,
    // since the block's depth store is not cleared at reset.
    function automatic dfmd_in_t pick_cell_word(input logic last);
        int s;
        int c;
        s = $urandom_range(0, SENSORS - 1);
        do c = $urandom_range(0, CELLS - 1);
        while (sensor_warm[s] && !cell_seen[s * CELLS + c]);
        return cell_word(s, c, pick_mm(s * CELLS + c), 1'b1, last);
    endfunction

    // One well-formed frame of random cells with a little noise mixed in,
    // closed by a marker, a cell, or an ignored word.
    task automatic random_frame();
        int       n;
        dfmd_in_t w;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 70) : $urandom_range(0, 12);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < 8) begin
                if ($urandom_range(0, 1))
                    w = cell_word($urandom_range(0, 3), $urandom, $urandom, 1'b0, 1'b0);
                else
                    w = cell_word(SENSORS, $urandom, $urandom, 1'b1, 1'b0);
            end else begin
                w = pick_cell_word(1'b0);
            end
            send_word(w);
        end
        case ($urandom_range(0, 3))
            0, 1: w = cell_word($urandom_range(0, 3), $urandom, $urandom, 1'b0, 1'b1);
            2:    w = pick_cell_word(1'b1);
            default: w = cell_word(SENSORS, $urandom, $urandom, 1'b1, 1'b1);
        endcase
        send_word(w);
    endtask

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, field, got, want);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls on m_ready, and a check of each accepted
    // report against the oldest one owed.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (receiver_stalls && $urandom_range(0, 99) < 30) begin
            stall_left = pick_gap_len() - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : check_reports
        dfmd_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (frame_reports_q.size() == 0) begin
                report_mismatch("report with none owed, active_cells",
                                m_data.active_cells, 0);
            end else begin
                want = frame_reports_q.pop_front();
                if (m_data.activity !== want.activity)
                    report_mismatch("activity", m_data.activity, want.activity);
                if (m_data.active_cells !== want.active_cells)
                    report_mismatch("active_cells", m_data.active_cells, want.active_cells);
                if (m_data.moving_cells !== want.moving_cells)
                    report_mismatch("moving_cells", m_data.moving_cells, want.moving_cells);
                if (m_data.any_sensor !== want.any_sensor)
                    report_mismatch("any_sensor", m_data.any_sensor, want.any_sensor);
            end
        end
    end

    // Watchdog: a long run of cycles with no word moving on either channel
    // means the block has hung.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= HANG_LIMIT) begin
            $display("watchdog: no word accepted for %0d cycles", HANG_LIMIT);
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Two frames of 200 all-active words over every cell of every sensor.
    // Active counts must stop at 192, the moving count in the second frame;
    // the first has no history, so its activity rests on the active count
    // alone. It also writes each store entry, so later tests visit any cell.
    task automatic test_count_saturation();
        int       idx;
        dfmd_in_t w;
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
        load_settings(TRIGGER_MAX_RST, MOTION_DELTA_RST, 8'd192, 8'd192);
        for (int f = 0; f < 2; f++) begin
            for (int i = 0; i < 200; i++) begin
                idx = ((i / CELLS) % SENSORS) * CELLS + (i % CELLS);
                w = cell_word((i / CELLS) % SENSORS, i % CELLS,
                              (depth_mem[idx] == 16'd100) ? 16'd1000 : 16'd100,
                              1'b1, i == 199);
                send_word(w);
            end
        end
    endtask

    // Hand-picked words at the default settings: empty frames, markers,
    // an ignored sensor, the active limit on both sides, the motion delta
    // met and missed by one, a repeated cell and a close riding on a cell.
    task automatic test_directed_cases();
        load_settings(TRIGGER_MAX_RST, MOTION_DELTA_RST, TRIGGER_MIN_RST, MOTION_MIN_RST);
        send_word(cell_word(0, 0, 0, 1'b0, 1'b1));
        send_word(cell_word(2, 17, 16'h1234, 1'b0, 1'b0));
        send_word(cell_word(SENSORS, 9, 100, 1'b1, 1'b1));
        send_word(cell_word(0, 0, 0, 1'b1, 1'b0));
        send_word(cell_word(0, 1, 1, 1'b1, 1'b0));
        send_word(cell_word(0, 2, 1650, 1'b1, 1'b0));
        send_word(cell_word(0, 3, 1651, 1'b1, 1'b0));
        send_word(cell_word(1, 63, 16'hFFFF, 1'b1, 1'b0));
        send_word(cell_word(SENSORS, 63, 500, 1'b1, 1'b0));
        send_word(cell_word(2, 5, 500, 1'b1, 1'b1));
        send_word(cell_word(0, 0, 85, 1'b1, 1'b0));
        send_word(cell_word(0, 1, 86, 1'b1, 1'b0));
        send_word(cell_word(0, 2, 1566, 1'b1, 1'b0));
        send_word(cell_word(0, 3, 0, 1'b1, 1'b0));
        send_word(cell_word(1, 63, 1000, 1'b1, 1'b0));
        send_word(cell_word(0, 0, 300, 1'b1, 1'b0));
        send_word(cell_word(2, 5, 500, 1'b1, 1'b0));
        send_word(cell_word(3, 63, 16'hFFFF, 1'b0, 1'b1));
        send_word(cell_word(1, 63, 3000, 1'b1, 1'b0));
        send_word(cell_word(1, 63, 2900, 1'b1, 1'b0));
        send_word(cell_word(1, 63, 100, 1'b1, 1'b1));
    endtask

    // Each register taken to both ends of its range, a few frames apiece.
    task automatic test_register_extremes();
        logic [DIST_W-1:0] lims [7];
        logic [DIST_W-1:0] dlts [7];
        logic [CNT_W-1:0]  mins [7];
        lims = '{16'd0, 16'hFFFF, 16'd1650, 16'd1650, 16'd1650, 16'd1650, 16'hFFFF};
        dlts = '{16'd85, 16'd85, 16'd0, 16'hFFFF, 16'd85, 16'd85, 16'd0};
        mins = '{8'd2, 8'd2, 8'd2, 8'd2, 8'd0, 8'd192, 8'd0};
        for (int k = 0; k < 7; k++) begin
            load_settings(lims[k], dlts[k], mins[k], mins[k]);
            repeat (3) random_frame();
        end
    endtask

    // Random frames under random settings. Every third phase runs with no
    // idling at all; now and then the sender waits out all owed reports.
    task automatic test_random_traffic();
        logic [DIST_W-1:0] lim;
        logic [DIST_W-1:0] dlt;
        logic [CNT_W-1:0]  mina;
        logic [CNT_W-1:0]  minm;
        int                stop_at;
        for (int p = 0; p < 5; p++) begin
            case ($urandom_range(0, 4))
                0:       lim = '0;
                1:       lim = '1;
                2:       lim = DIST_W'($urandom);
                default: lim = DIST_W'($urandom_range(200, 3000));
            endcase
            case ($urandom_range(0, 4))
                0:       dlt = '0;
                1:       dlt = '1;
                default: dlt = DIST_W'($urandom_range(1, 400));
            endcase
            mina = ($urandom_range(0, 5) == 0) ? 8'd192 : CNT_W'($urandom_range(0, 8));
            minm = ($urandom_range(0, 5) == 0) ? 8'd192 : CNT_W'($urandom_range(0, 8));
            load_settings(lim, dlt, mina, minm);
            sender_gaps     = (p % 3 != 0);
            receiver_stalls = (p % 3 != 0);
            stop_at = words_sent + 120;
            while (words_sent < stop_at) begin
                random_frame();
                if ($urandom_range(0, 9) == 0) wait_for_reports();
            end
        end
    endtask

    initial begin
        foreach (depth_mem[i]) begin
            depth_mem[i] = '0;
            cell_seen[i] = 1'b0;
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        test_count_saturation();
        test_directed_cases();
        test_register_extremes();
        test_random_traffic();

        // Drain, then leave room for any stray report before the verdict.
        wait_for_reports();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
